// ===== src/hbridge_motor_drive_voltage_comp_macros.svh =====
// Assertion helpers shared by the controller and the datapath.
// Both expect i_clk and i_rst_n in scope.
`ifndef HBRIDGE_MOTOR_DRIVE_VOLTAGE_COMP_MACROS_SVH
`define HBRIDGE_MOTOR_DRIVE_VOLTAGE_COMP_MACROS_SVH

// Consequent must hold in the same cycle.
`define HBVC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbvc assertion failed");

// Consequent must hold in the following cycle.
`define HBVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbvc assertion failed");

`endif

// ===== src/hbvc_pkg.sv =====
`timescale 1ns / 1ps
package hbvc_pkg;

    typedef enum logic [1:0] {
        OP_SPEED   = 2'd0,
        OP_VOLTAGE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        POL_STOP = 2'd0,
        POL_FWD  = 2'd1,
        POL_REV  = 2'd3
    } t_polarity;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_EMIT
    } t_state;

    localparam logic [1:0] CFG_PWM_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_TARGET_MV   = 2'd1;
    localparam logic [1:0] CFG_BRAKE_TICKS = 2'd2;

    localparam logic [15:0] RST_PWM_PERIOD  = 16'd1000;
    localparam logic [15:0] RST_TARGET_MV   = 16'd12000;
    localparam logic [15:0] RST_BRAKE_TICKS = 16'd10;

    localparam logic [15:0] MIN_MV    = 16'd100;
    localparam logic [16:0] RATIO_ONE = 17'h10000;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic accept;
        logic decode;
        logic mul1;
        logic mul2;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/hbvc_ctrl.sv =====
`timescale 1ns / 1ps
`include "hbridge_motor_drive_voltage_comp_macros.svh"
module hbvc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hbvc_pkg::t_status i_status,
    output hbvc_pkg::t_cmd  o_cmd,
    output logic            o_stall
);

    hbvc_pkg::t_state r_state;
    hbvc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hbvc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = hbvc_pkg::ST_DECODE;
                end
            end
            hbvc_pkg::ST_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_status.need_mul) begin
                    n_state = hbvc_pkg::ST_MUL1;
                end else if (i_status.need_div) begin
                    n_state = hbvc_pkg::ST_DIV;
                end else begin
                    n_state = hbvc_pkg::ST_EMIT;
                end
            end
            hbvc_pkg::ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = hbvc_pkg::ST_MUL2;
            end
            hbvc_pkg::ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = hbvc_pkg::ST_EMIT;
            end
            hbvc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = hbvc_pkg::ST_EMIT;
                end
            end
            hbvc_pkg::ST_EMIT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = hbvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hbvc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != hbvc_pkg::ST_IDLE);

    `HBVC_ASSERT_NEXT(a_accept_decodes, o_cmd.accept, r_state == hbvc_pkg::ST_DECODE)
    `HBVC_ASSERT_NEXT(a_div_holds, (r_state == hbvc_pkg::ST_DIV) && !i_status.div_last, r_state == hbvc_pkg::ST_DIV)
    `HBVC_ASSERT_NEXT(a_emit_returns, o_cmd.emit, r_state == hbvc_pkg::ST_IDLE)

endmodule

// ===== src/hbvc_dp.sv =====
`timescale 1ns / 1ps
`include "hbridge_motor_drive_voltage_comp_macros.svh"
module hbvc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_op,
    input  logic signed [15:0] i_direction,
    input  logic [15:0]       i_voltage_mv,
    input  hbvc_pkg::t_cmd    i_cmd,
    input  logic              i_stall,
    output hbvc_pkg::t_status o_status,
    output logic              o_valid,
    output logic [15:0]       o_compare_value,
    output logic              o_pin_a,
    output logic              o_pin_b,
    output logic              o_braking
);

    // configuration
    logic [15:0] r_pwm_period;
    logic [15:0] r_target_mv;
    logic [15:0] r_brake_ticks;

    // latched transaction
    logic [1:0]        r_op;
    logic signed [15:0] r_dir;
    logic [15:0]       r_vmv;

    // drive state
    hbvc_pkg::t_polarity r_polarity;
    logic [16:0]       r_ratio;
    logic [15:0]       r_brake_count;
    logic signed [15:0] r_pending;
    logic [15:0]       r_compare;
    logic              r_pin_a;
    logic              r_pin_b;
    logic signed [15:0] r_apply_dir;

    // arithmetic
    logic [31:0]       r_prod1;
    logic [15:0]       r_div_rem;
    logic [15:0]       r_div_divisor;
    logic [15:0]       r_div_q;
    logic [hbvc_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic              r_out_valid;
    logic              n_out_valid;
    logic [15:0]       r_out_compare;
    logic              r_out_a;
    logic              r_out_b;
    logic              r_out_braking;

    logic              w_dir_pos;
    logic              w_dir_neg;
    logic              w_reverse;
    logic              w_brake_start;
    logic              w_apply;
    logic signed [15:0] w_apply_dir;
    logic [15:0]       w_v;
    logic [16:0]       w_mag;
    logic [32:0]       w_prod1;
    logic [48:0]       w_prod2;
    logic [16:0]       w_rem2;
    logic              w_ge;
    logic [15:0]       w_rem_next;
    logic [15:0]       w_q_next;

    always_comb begin
        w_dir_pos     = !r_dir[15] && (r_dir != 16'sd0);
        w_dir_neg     = r_dir[15];
        w_reverse     = ((r_polarity == hbvc_pkg::POL_FWD) && w_dir_neg) ||
                        ((r_polarity == hbvc_pkg::POL_REV) && w_dir_pos);
        w_brake_start = 1'b0;
        w_apply       = 1'b0;
        w_apply_dir   = r_dir;
        case (r_op)
            hbvc_pkg::OP_SPEED: begin
                if (r_brake_count == 16'd0) begin
                    if (w_reverse && (r_brake_ticks != 16'd0)) begin
                        w_brake_start = 1'b1;
                    end else begin
                        w_apply = 1'b1;
                    end
                end
            end
            hbvc_pkg::OP_TICK: begin
                if (r_brake_count == 16'd1) begin
                    w_apply     = 1'b1;
                    w_apply_dir = r_pending;
                end
            end
            default: begin
            end
        endcase
        w_v = (r_vmv < hbvc_pkg::MIN_MV) ? hbvc_pkg::MIN_MV : r_vmv;
    end

    always_comb begin
        o_status.need_mul = w_apply && (w_apply_dir != 16'sd0);
        o_status.need_div = (r_op == hbvc_pkg::OP_VOLTAGE) && (r_target_mv < w_v);
        o_status.div_last = (r_div_cnt == '0);
        o_status.out_free = !r_out_valid || !i_stall;
    end

    // magnitude of the applied command, 32768 needs the extra bit
    assign w_mag   = r_apply_dir[15] ? (17'd0 - {r_apply_dir[15], r_apply_dir})
                                     : {1'b0, r_apply_dir};
    assign w_prod1 = 33'(w_mag) * 33'(r_pwm_period);
    assign w_prod2 = 49'(r_prod1) * 49'(r_ratio);

    assign w_rem2     = {r_div_rem, 1'b0};
    assign w_ge       = (w_rem2 >= {1'b0, r_div_divisor});
    assign w_rem_next = w_ge ? 16'(w_rem2 - {1'b0, r_div_divisor}) : w_rem2[15:0];
    assign w_q_next   = {r_div_q[14:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= hbvc_pkg::RST_PWM_PERIOD;
            r_target_mv   <= hbvc_pkg::RST_TARGET_MV;
            r_brake_ticks <= hbvc_pkg::RST_BRAKE_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbvc_pkg::CFG_PWM_PERIOD:  r_pwm_period  <= i_cfg_data;
                hbvc_pkg::CFG_TARGET_MV:   r_target_mv   <= i_cfg_data;
                hbvc_pkg::CFG_BRAKE_TICKS: r_brake_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_dir <= i_direction;
            r_vmv <= i_voltage_mv;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= w_prod1[31:0];
        end
        if (i_cmd.decode) begin
            r_apply_dir   <= w_apply_dir;
            r_div_rem     <= r_target_mv;
            r_div_divisor <= w_v;
            r_div_q       <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_rem_next;
            r_div_q   <= w_q_next;
        end
        if (i_cmd.emit) begin
            r_out_compare <= r_compare;
            r_out_a       <= r_pin_a;
            r_out_b       <= r_pin_b;
            r_out_braking <= (r_brake_count != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity    <= hbvc_pkg::POL_STOP;
            r_ratio       <= hbvc_pkg::RATIO_ONE;
            r_brake_count <= '0;
            r_pending     <= '0;
            r_compare     <= '0;
            r_pin_a       <= 1'b1;
            r_pin_b       <= 1'b1;
            r_div_cnt     <= '0;
        end else begin
            if (i_cmd.decode) begin
                r_div_cnt <= hbvc_pkg::DIV_CNT_W'(hbvc_pkg::DIV_STEPS - 1);
                case (r_op)
                    hbvc_pkg::OP_SPEED: begin
                        // during a brake only the pending command moves
                        if ((r_brake_count != 16'd0) || w_brake_start) begin
                            r_pending <= r_dir;
                        end
                        if (w_brake_start) begin
                            r_brake_count <= r_brake_ticks;
                        end
                    end
                    hbvc_pkg::OP_VOLTAGE: begin
                        if (r_target_mv >= w_v) begin
                            r_ratio <= hbvc_pkg::RATIO_ONE;
                        end
                    end
                    hbvc_pkg::OP_TICK: begin
                        if (r_brake_count != 16'd0) begin
                            r_brake_count <= r_brake_count - 16'd1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_brake_start || (w_apply && (w_apply_dir == 16'sd0))) begin
                    r_polarity <= hbvc_pkg::POL_STOP;
                    r_compare  <= '0;
                    r_pin_a    <= 1'b1;
                    r_pin_b    <= 1'b1;
                end else if (w_apply) begin
                    r_polarity <= w_apply_dir[15] ? hbvc_pkg::POL_REV : hbvc_pkg::POL_FWD;
                    r_pin_a    <= !w_apply_dir[15];
                    r_pin_b    <= w_apply_dir[15];
                end
            end
            if (i_cmd.mul2) begin
                r_compare <= w_prod2[46:31];
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    r_ratio <= {1'b0, w_q_next};
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_compare_value = r_out_compare;
    assign o_pin_a         = r_out_a;
    assign o_pin_b         = r_out_b;
    assign o_braking       = r_out_braking;

    `HBVC_ASSERT_NOW(a_brake_drive, r_brake_count != 16'd0, (r_polarity == hbvc_pkg::POL_STOP) && (r_compare == 16'd0) && r_pin_a && r_pin_b)
    `HBVC_ASSERT_NOW(a_ratio_max, r_ratio[16], r_ratio[15:0] == 16'd0)
    `HBVC_ASSERT_NOW(a_div_rem, i_cmd.div_step, r_div_rem < r_div_divisor)

endmodule

// ===== src/hbridge_motor_drive_voltage_comp.sv =====
`timescale 1ns / 1ps
// H-bridge drive with supply compensation.
// Input channel (i_valid / o_stall): op 0 speed command on i_direction, op 1 supply
// sample on i_voltage_mv, op 2 time tick. One transaction at a time is taken.
// Output channel (o_valid / i_stall): exactly one result per input transaction,
// showing the compare value, bridge pins and brake flag now applied.
// From accept the block steps through decode, then emit, which loads the output
// register. A nonzero command taking effect adds two registered multiplies; a
// supply sample above target adds a 16-step restoring divider, one quotient bit
// per cycle. A new transaction is taken only once the last one is emitted, so
// the divider path bounds the rate.
// The next transaction is accepted while a result still waits in the output
// register; a stall held while a result waits holds the block in its emit state.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
// and belong in idle periods.
// Reset (synchronous, active low) restores register defaults, sets the drive state
// to stopped with compare 0 and both pins high, ratio one, and clears any pending output.
module hbridge_motor_drive_voltage_comp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_op,
    input  logic signed [15:0] i_direction,
    input  logic [15:0]       i_voltage_mv,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_compare_value,
    output logic              o_pin_a,
    output logic              o_pin_b,
    output logic              o_braking
);

    hbvc_pkg::t_cmd    w_cmd;
    hbvc_pkg::t_status w_status;

    hbvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    hbvc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_direction     (i_direction),
        .i_voltage_mv    (i_voltage_mv),
        .i_cmd           (w_cmd),
        .i_stall         (i_stall),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_compare_value (o_compare_value),
        .o_pin_a         (o_pin_a),
        .o_pin_b         (o_pin_b),
        .o_braking       (o_braking)
    );

endmodule
